### design/scw_pkg.sv
// ----------------------------------------------------------------------------
// scw_pkg: shared types and constants of the strike and product word checker
// Opcode and status codes, register map and fixed field widths.
// ----------------------------------------------------------------------------
package scw_pkg;

	// Field widths fixed by the interface
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned STRIKE_W = 8;
	localparam int unsigned EXPR_W   = 16;
	localparam int unsigned ADDR_W   = 4;
	localparam int unsigned DATA_W   = 32;

	// Default sizes of the info page layout
	localparam int unsigned DEF_STRIKE_WORDS = 128;
	localparam int unsigned DEF_MAX_EXPRS    = 256;

	localparam logic [WORD_W-1:0] ALL_ONES = '1;

	// Input word opcodes
	typedef enum logic [1:0] {
		OP_START   = 2'd0,
		OP_STRIKE  = 2'd1,
		OP_PRODUCT = 2'd2,
		OP_FINISH  = 2'd3
	} opcode_t;

	// Result status codes, in precedence order after OK
	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_NOT_PRESENT  = 3'd1,
		ST_COUNT_LARGE  = 3'd2,
		ST_STRIKE_FAIL  = 3'd3,
		ST_PRODUCT_FAIL = 3'd4,
		ST_MISMATCH     = 3'd5
	} status_t;

	// Register index (byte address bits [3:2])
	typedef enum logic [1:0] {
		REG_FEATURE_PRESENT  = 2'd0,
		REG_OWNER_EXPR_LIMIT = 2'd1,
		REG_EXPR_COUNT       = 2'd2,
		REG_UNUSED           = 2'd3
	} reg_idx_t;

endpackage

### design/strike_and_product_word_checker_core.sv
// ----------------------------------------------------------------------------
// strike_and_product_word_checker_core: info page strike/product word checker
// Counts good and bad strike words and product expressions and reports one
// status word with a checks count on each finish word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one word per accepted cycle:
//   opcode, flash_word, strike_mark, expr_mask, expr_value. Start clears the
//   counters, strike and product words update them, finish emits a result.
//   Output channel (out_valid/out_stall) carries status and checks_performed,
//   only for finish words.
//   Throughput: one word per cycle while in_stall is low. A finish word's result
//   passes through the input register, then the result register.
//   The counters sit between those two registers; one compare and one
//   increment per word set the cycle.
//   When the receiver stalls, the result register holds; non-finish words
//   keep flowing, and a finish word waits in the input register, which then
//   stalls the input channel until the result is taken.
//   Reset (arst_n low) clears counters, configuration registers and both valid flags.
//   The APB port writes feature_present (0x0), owner_expr_limit (0x4) and
//   expr_count (0x8); pready is always high. Write only while idle.
// ----------------------------------------------------------------------------
module strike_and_product_word_checker_core #(
	parameter int unsigned STRIKE_WORDS = scw_pkg::DEF_STRIKE_WORDS,
	parameter int unsigned MAX_EXPRS    = scw_pkg::DEF_MAX_EXPRS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [scw_pkg::ADDR_W-1:0]   paddr,
	input  logic [scw_pkg::DATA_W-1:0]   pwdata,
	output logic [scw_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	// input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   opcode,
	input  logic [scw_pkg::WORD_W-1:0]   flash_word,
	input  logic                         strike_mark,
	input  logic [scw_pkg::WORD_W-1:0]   expr_mask,
	input  logic [scw_pkg::WORD_W-1:0]   expr_value,
	// output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [2:0]                   status,
	output logic [scw_pkg::WORD_W-1:0]   checks_performed
);

	localparam int unsigned SUM_S_W = scw_pkg::STRIKE_W + 1;
	localparam int unsigned SUM_E_W = scw_pkg::EXPR_W + 1;

	// configuration registers
	logic                         feature_present_q;
	logic [scw_pkg::EXPR_W-1:0]   owner_expr_limit_q;
	logic [scw_pkg::EXPR_W-1:0]   expr_count_q;

	// input register stage
	logic                         valid_s1;
	scw_pkg::opcode_t             opcode_s1;
	logic [scw_pkg::WORD_W-1:0]   flash_word_s1;
	logic                         strike_mark_s1;
	logic [scw_pkg::WORD_W-1:0]   expr_mask_s1;
	logic [scw_pkg::WORD_W-1:0]   expr_value_s1;

	// check counters
	logic [scw_pkg::STRIKE_W-1:0] strike_ok_q;
	logic [scw_pkg::STRIKE_W-1:0] strike_bad_q;
	logic [scw_pkg::EXPR_W-1:0]   expr_ok_q;
	logic [scw_pkg::EXPR_W-1:0]   expr_bad_q;
	logic                         seq_fault_q;

	// result register
	logic                         out_valid_q;
	scw_pkg::status_t             status_q;
	logic [scw_pkg::WORD_W-1:0]   checks_q;

	logic                         in_accept;
	logic                         out_free;
	logic                         advance;
	logic                         apb_write;
	scw_pkg::reg_idx_t            reg_idx;
	logic [SUM_S_W-1:0]           strike_sum;
	logic [SUM_E_W-1:0]           expr_sum;
	logic                         strike_full;
	logic                         expr_full;
	logic                         strike_bad;
	logic                         expr_pass;
	scw_pkg::status_t             status_nxt;
	logic [scw_pkg::WORD_W-1:0]   checks_nxt;

	// ------------------------------------------------------------------------
	// APB register file
	// ------------------------------------------------------------------------
	assign pready    = 1'b1;
	assign reg_idx   = scw_pkg::reg_idx_t'(paddr[3:2]);
	assign apb_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feature_present_q  <= 1'b0;
			owner_expr_limit_q <= '0;
			expr_count_q       <= '0;
		end else if (apb_write) begin
			case (reg_idx)
				scw_pkg::REG_FEATURE_PRESENT:  feature_present_q  <= pwdata[0];
				scw_pkg::REG_OWNER_EXPR_LIMIT: owner_expr_limit_q <= pwdata[scw_pkg::EXPR_W-1:0];
				scw_pkg::REG_EXPR_COUNT:       expr_count_q       <= pwdata[scw_pkg::EXPR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			scw_pkg::REG_FEATURE_PRESENT:
				prdata = {{(scw_pkg::DATA_W-1){1'b0}}, feature_present_q};
			scw_pkg::REG_OWNER_EXPR_LIMIT:
				prdata = {{(scw_pkg::DATA_W-scw_pkg::EXPR_W){1'b0}}, owner_expr_limit_q};
			scw_pkg::REG_EXPR_COUNT:
				prdata = {{(scw_pkg::DATA_W-scw_pkg::EXPR_W){1'b0}}, expr_count_q};
			default:
				prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------------
	// Handshake: a finish word waits in s1 while the result register is held
	// ------------------------------------------------------------------------
	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && ((opcode_s1 != scw_pkg::OP_FINISH) || out_free);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			opcode_s1      <= scw_pkg::opcode_t'(opcode);
			flash_word_s1  <= flash_word;
			strike_mark_s1 <= strike_mark;
			expr_mask_s1   <= expr_mask;
			expr_value_s1  <= expr_value;
		end
	end

	// ------------------------------------------------------------------------
	// Word checks
	// ------------------------------------------------------------------------
	assign strike_sum  = SUM_S_W'(strike_ok_q) + SUM_S_W'(strike_bad_q);
	assign expr_sum    = SUM_E_W'(expr_ok_q) + SUM_E_W'(expr_bad_q);
	assign strike_full = strike_sum >= SUM_S_W'(STRIKE_WORDS);
	assign expr_full   = expr_sum >= SUM_E_W'(expr_count_q);
	assign strike_bad  = strike_mark_s1 && (flash_word_s1 != scw_pkg::ALL_ONES);
	assign expr_pass   = (flash_word_s1 & expr_mask_s1) == expr_value_s1;

	// counter update as each word leaves s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strike_ok_q  <= '0;
			strike_bad_q <= '0;
			expr_ok_q    <= '0;
			expr_bad_q   <= '0;
			seq_fault_q  <= 1'b0;
		end else if (advance) begin
			case (opcode_s1)
				scw_pkg::OP_START: begin
					strike_ok_q  <= '0;
					strike_bad_q <= '0;
					expr_ok_q    <= '0;
					expr_bad_q   <= '0;
					seq_fault_q  <= 1'b0;
				end
				scw_pkg::OP_STRIKE: begin
					// strike after any product word, or beyond the page size
					if ((expr_sum != '0) || strike_full) begin
						seq_fault_q <= 1'b1;
					end else if (strike_bad) begin
						strike_bad_q <= strike_bad_q + scw_pkg::STRIKE_W'(1);
					end else begin
						strike_ok_q <= strike_ok_q + scw_pkg::STRIKE_W'(1);
					end
				end
				scw_pkg::OP_PRODUCT: begin
					if (expr_full) begin
						seq_fault_q <= 1'b1;
					end else if (expr_pass) begin
						expr_ok_q <= expr_ok_q + scw_pkg::EXPR_W'(1);
					end else begin
						expr_bad_q <= expr_bad_q + scw_pkg::EXPR_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Final status, in precedence order
	// ------------------------------------------------------------------------
	always_comb begin
		if (!feature_present_q) begin
			status_nxt = scw_pkg::ST_NOT_PRESENT;
		end else if ((expr_count_q > owner_expr_limit_q) ||
				(SUM_E_W'(expr_count_q) > SUM_E_W'(MAX_EXPRS))) begin
			status_nxt = scw_pkg::ST_COUNT_LARGE;
		end else if (strike_bad_q != '0) begin
			status_nxt = scw_pkg::ST_STRIKE_FAIL;
		end else if (expr_bad_q != '0) begin
			status_nxt = scw_pkg::ST_PRODUCT_FAIL;
		end else if ((strike_ok_q != scw_pkg::STRIKE_W'(STRIKE_WORDS)) ||
				(expr_ok_q != expr_count_q) || seq_fault_q) begin
			status_nxt = scw_pkg::ST_MISMATCH;
		end else begin
			status_nxt = scw_pkg::ST_OK;
		end
	end

	assign checks_nxt = (status_nxt == scw_pkg::ST_OK) ?
		(scw_pkg::WORD_W'(STRIKE_WORDS) + scw_pkg::WORD_W'(expr_count_q)) :
		scw_pkg::ALL_ONES;

	// ------------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && (opcode_s1 == scw_pkg::OP_FINISH);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && (opcode_s1 == scw_pkg::OP_FINISH)) begin
			status_q <= status_nxt;
			checks_q <= checks_nxt;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign checks_performed = checks_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	// counted strike words never exceed the page size
	a_strike_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(SUM_S_W'(strike_ok_q) + SUM_S_W'(strike_bad_q)) <= SUM_S_W'(STRIKE_WORDS))
		else $error("strike counters exceed page size");

	// a start word leaving s1 clears every counter
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (opcode_s1 == scw_pkg::OP_START) |=>
		(strike_ok_q == '0) && (strike_bad_q == '0) && (expr_ok_q == '0) &&
		(expr_bad_q == '0) && !seq_fault_q)
		else $error("start word did not clear counters");

	// failing status always reports all ones
	a_fail_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != scw_pkg::ST_OK) |-> checks_q == scw_pkg::ALL_ONES)
		else $error("failing status with a real checks count");

	// passing status never reports all ones
	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == scw_pkg::ST_OK) |-> checks_q != scw_pkg::ALL_ONES)
		else $error("passing status with all-ones checks count");

	// input stalls only behind a finish word held by a full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && (opcode_s1 == scw_pkg::OP_FINISH) &&
		out_valid_q && out_stall)
		else $error("input stalled without a held finish word");

endmodule
